// File: sv/wvcp_pkg.sv
// ----------------------------------------------------------------------------
// wvcp_pkg
// Types and constants shared by the weighted vertex cover pricing block.
// ----------------------------------------------------------------------------
`default_nettype none

package wvcp_pkg;

    localparam int VERTEX_W         = 6;
    localparam int WEIGHT_W         = 16;
    localparam int MASK_W           = 64;
    localparam int OPCODE_W         = 2;
    localparam int MAX_VERTICES_DEF = 64;

    localparam logic [OPCODE_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_EDGE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_MASK = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [VERTEX_W-1:0] vertex_a;
        logic [VERTEX_W-1:0] vertex_b;
        logic [WEIGHT_W-1:0] weight;
    } wvcp_in_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0] price;
        logic                skipped;
        logic [MASK_W-1:0]   cover_bits;
    } wvcp_out_t;

    // Single write port of the weight store
    typedef struct packed {
        logic                en;
        logic [VERTEX_W-1:0] addr;
        logic [WEIGHT_W-1:0] data;
    } wvcp_wr_t;

endpackage

`default_nettype wire

// File: sv/wvcp_weight_ram.sv
// ----------------------------------------------------------------------------
// wvcp_weight_ram
// Remaining-weight store: one write port, two registered read ports with
// write-through bypass so a read in the write cycle sees the new data.
// ----------------------------------------------------------------------------
`default_nettype none

module wvcp_weight_ram
    import wvcp_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  wire logic                aclk,
    input  wire wvcp_wr_t            wr,
    input  wire logic                rd_en,
    input  wire logic [VERTEX_W-1:0] rd_addr_a,
    input  wire logic [VERTEX_W-1:0] rd_addr_b,
    output logic      [WEIGHT_W-1:0] rd_data_a,
    output logic      [WEIGHT_W-1:0] rd_data_b
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

    logic [WEIGHT_W-1:0] mem [MAX_VERTICES];
    logic [WEIGHT_W-1:0] rd_a_reg;
    logic [WEIGHT_W-1:0] rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr[AW-1:0]] <= wr.data;
        end
        if (rd_en) begin
            rd_a_reg <= (wr.en && wr.addr == rd_addr_a) ? wr.data : mem[rd_addr_a[AW-1:0]];
            rd_b_reg <= (wr.en && wr.addr == rd_addr_b) ? wr.data : mem[rd_addr_b[AW-1:0]];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

`default_nettype wire

// File: sv/weighted_vertex_cover_pricing_top.sv
// ----------------------------------------------------------------------------
// weighted_vertex_cover_pricing_top
// Pricing-method weighted vertex cover over a stream of operations.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one operation per transaction: load a vertex weight (also
//   drops the vertex from the cover), price an edge, or read the cover mask.
//   m_* returns exactly one result per operation, in order.
//   A transaction accepted on s_* is held in the operation register,
//   then its result in the result register that drives m_*. Throughput:
//   one operation per cycle while m_* does not stall, set by the weight
//   store's two read ports and single write port; the payer of an edge is
//   recorded in the cover bits, so each edge needs only one write. Back-to-back
//   edges on the same vertex are served by write-through forwarding in the weight store.
//   Reset (aresetn low, synchronous) empties the pipeline and clears the
//   cover; vertex weights are undefined until loaded.
//   When m_ready is low a full result register holds, the stage behind it
//   holds, and s_ready drops once both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_vertex_cover_pricing_top
    import wvcp_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire wvcp_in_t  s_payload,
    output logic           m_valid,
    input  wire logic      m_ready,
    output wvcp_out_t      m_payload
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam logic [VERTEX_W:0] VLIMIT = (VERTEX_W+1)'(MAX_VERTICES);

    logic                    s1_valid_reg;
    wvcp_in_t                s1_item_reg;
    logic                    m_valid_reg;
    wvcp_out_t               m_payload_reg;
    logic [MAX_VERTICES-1:0] cover_reg;
    logic [MAX_VERTICES-1:0] cover_next;
    wvcp_out_t               result;
    wvcp_wr_t                wr;

    logic                accept;
    logic                adv;
    logic [WEIGHT_W-1:0] rd_a;
    logic [WEIGHT_W-1:0] rd_b;
    logic [VERTEX_W-1:0] va;
    logic [VERTEX_W-1:0] vb;
    logic                ok_a;
    logic                ok_b;
    logic [WEIGHT_W-1:0] wa;
    logic [WEIGHT_W-1:0] wb;
    logic                do_load;
    logic                do_edge;
    logic                exhausted;
    logic                a_pays;
    logic                self_loop;
    logic [WEIGHT_W-1:0] price;
    logic [WEIGHT_W-1:0] other_w;
    logic [VERTEX_W-1:0] payer;
    logic [VERTEX_W-1:0] other;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = !s1_valid_reg || adv;
    assign accept  = s_valid && s_ready;

    wvcp_weight_ram #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_weight_ram (
        .aclk      (aclk),
        .wr        (wr),
        .rd_en     (accept),
        .rd_addr_a (s_payload.vertex_a),
        .rd_addr_b (s_payload.vertex_b),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    // Datapath of the held operation
    assign va   = s1_item_reg.vertex_a;
    assign vb   = s1_item_reg.vertex_b;
    assign ok_a = ({1'b0, va} < VLIMIT);
    assign ok_b = ({1'b0, vb} < VLIMIT);

    // A vertex in the cover has zero remaining weight regardless of the store
    assign wa = cover_reg[va[AW-1:0]] ? '0 : rd_a;
    assign wb = cover_reg[vb[AW-1:0]] ? '0 : rd_b;

    assign do_load   = s1_valid_reg && adv && s1_item_reg.opcode == OP_LOAD && ok_a;
    assign do_edge   = s1_valid_reg && s1_item_reg.opcode == OP_EDGE && ok_a && ok_b;
    assign exhausted = (wa == '0) || (wb == '0);
    assign a_pays    = wa < wb;
    assign self_loop = va == vb;
    assign price     = a_pays ? wa : wb;
    assign other_w   = a_pays ? (wb - wa) : (wa - wb);
    assign payer     = a_pays ? va : vb;
    assign other     = a_pays ? vb : va;

    always_comb begin
        wr = '{en: 1'b0, addr: va, data: s1_item_reg.weight};
        if (do_load) begin
            wr.en = 1'b1;
        end else if (adv && do_edge && !exhausted && !self_loop) begin
            wr = '{en: 1'b1, addr: other, data: other_w};
        end
    end

    always_comb begin
        cover_next = cover_reg;
        if (do_load) begin
            cover_next[va[AW-1:0]] = 1'b0;
        end else if (adv && do_edge) begin
            if (exhausted) begin
                if (wa == '0) begin
                    cover_next[va[AW-1:0]] = 1'b1;
                end
                if (wb == '0) begin
                    cover_next[vb[AW-1:0]] = 1'b1;
                end
            end else begin
                cover_next[payer[AW-1:0]] = 1'b1;
                if (!self_loop && other_w == '0) begin
                    cover_next[other[AW-1:0]] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        result.price      = (do_edge && !exhausted) ? price : '0;
        result.skipped    = do_edge && exhausted;
        result.cover_bits = (s1_item_reg.opcode == OP_MASK) ? MASK_W'(cover_reg) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            cover_reg    <= '0;
        end else begin
            cover_reg <= cover_next;
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (adv) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_item_reg <= s_payload;
        end
        if (adv) begin
            m_payload_reg <= result;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

`default_nettype wire

// File: sv/wvcp_checker.sv
// ----------------------------------------------------------------------------
// wvcp_checker
// Port-level checks for the vertex cover pricing block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module wvcp_checker
    import wvcp_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire wvcp_out_t m_payload
);

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result transaction holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("stalled result changed");

    // A skipped edge is never charged
    a_skip_free: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.skipped |-> m_payload.price == '0)
        else $error("skipped edge carries a price");

    // A mask read carries no edge result
    a_mask_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.cover_bits != '0 |-> m_payload.price == '0 && !m_payload.skipped)
        else $error("mask result mixed with edge result");

    // With a free output, the block never refuses an operation
    a_no_bubble: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

endmodule

bind weighted_vertex_cover_pricing_top wvcp_checker u_wvcp_checker (.*);

`default_nettype wire
